FILE: sv/scua_pkg.sv
package scua_pkg;

  localparam int MIN_SIZE_EXP    = 3;
  localparam int MAX_SIZE_EXP    = 12;
  localparam int UNITS_PER_CLASS = 256;
  localparam int NUM_CLASSES     = (MAX_SIZE_EXP >= MIN_SIZE_EXP) ?
                                   (MAX_SIZE_EXP - MIN_SIZE_EXP + 1) : 1;

  localparam int MODE_W  = 2;
  localparam int SIZE_W  = 13;
  localparam int CLASS_W = 4;
  localparam int HUNIT_W = 8;
  localparam int STAT_W  = 2;
  localparam int BYTES_W = 13;
  localparam int TOTAL_W = 12;

  localparam int UNIT_W  = (UNITS_PER_CLASS > 1) ? $clog2(UNITS_PER_CLASS) : 1;
  localparam int CNT_W   = $clog2(UNITS_PER_CLASS + 1);
  localparam int RAM_DEPTH = NUM_CLASSES * UNITS_PER_CLASS;
  localparam int ADDR_W  = CLASS_W + UNIT_W;

  localparam int IN_W  = MODE_W + SIZE_W + CLASS_W + HUNIT_W;
  localparam int OUT_W = STAT_W + CLASS_W + HUNIT_W + BYTES_W + TOTAL_W;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESIZE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_UNIT   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_POP,
    S_PUSH,
    S_OUT
  } state_t;

  typedef struct packed {
    logic take;
    logic decide;
    logic pop;
    logic push;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic alloc_ok;
    logic is_free;
    logic resize_alloc;
    logic out_busy;
  } sts_t;

  // smallest e with s <= 2^e, for s > 1
  function automatic logic [4:0] ceil_pow2_exp(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] m;
    logic [4:0]        e;
    m = s - SIZE_W'(1);
    e = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (m[i]) e = 5'(i + 1);
    end
    return e;
  endfunction

  function automatic logic [BYTES_W-1:0] class_bytes(input logic [CLASS_W-1:0] c);
    return BYTES_W'(1) << (5'(c) + 5'(MIN_SIZE_EXP));
  endfunction

endpackage

FILE: sv/scua_ram.sv
module scua_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: sv/scua_ctrl.sv
module scua_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  scua_pkg::sts_t sts,
  output scua_pkg::cmd_t cmd,
  output logic          in_ready
);

  import scua_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_READ;
      end
      S_READ: begin
        priority if (sts.alloc_ok) state_next = S_POP;
        else if (sts.is_free)      state_next = S_PUSH;
        else                       state_next = S_OUT;
      end
      S_POP: begin
        state_next = sts.resize_alloc ? S_PUSH : S_OUT;
      end
      S_PUSH: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = 1'b1;
      end
      S_READ: cmd.decide = 1'b1;
      S_POP:  cmd.pop    = 1'b1;
      S_PUSH: cmd.push   = 1'b1;
      S_OUT:  cmd.load   = !sts.out_busy;
      default: ;
    endcase
  end

endmodule

FILE: sv/scua_dp.sv
module scua_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  scua_pkg::cmd_t                    cmd,
  output scua_pkg::sts_t                    sts,
  input  logic                              in_valid,
  input  logic [scua_pkg::IN_TDATA_W-1:0]   in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [scua_pkg::OUT_TDATA_W-1:0]  out_data
);

  import scua_pkg::*;

  // request
  logic [MODE_W-1:0]  mode;
  logic [SIZE_W-1:0]  request_size;
  logic [CLASS_W-1:0] handle_class;
  logic [HUNIT_W-1:0] handle_unit;

  // result
  logic [STAT_W-1:0]  res_status;
  logic [CLASS_W-1:0] res_class;
  logic [HUNIT_W-1:0] res_unit;
  logic [BYTES_W-1:0] res_bytes;
  logic               use_init;

  // allocator state
  logic [CNT_W-1:0]   cnt [NUM_CLASSES];
  logic [CNT_W-1:0]   low [NUM_CLASSES];
  logic [TOTAL_W-1:0] total;

  logic [OUT_W-1:0]   out_reg;

  // decode
  logic               hvalid, fits, need_alloc, too_large, alloc_ok;
  logic [4:0]         exp_v;
  logic [CLASS_W-1:0] aclass, hidx;
  logic [CNT_W-1:0]   acnt, hcnt, pcnt;
  logic               hfull;

  logic               ram_en, ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [UNIT_W-1:0]  ram_rdata;
  logic [UNIT_W-1:0]  pop_unit;

  always_comb begin
    hvalid = (32'(handle_class) < NUM_CLASSES) && (32'(handle_unit) < UNITS_PER_CLASS);
    hidx   = hvalid ? handle_class : '0;
    hcnt   = cnt[hidx];
    hfull  = 32'(hcnt) >= UNITS_PER_CLASS;
    fits   = hvalid && (14'(request_size) <= 14'(class_bytes(handle_class)));
    need_alloc = (mode == MODE_ALLOC) || ((mode == MODE_RESIZE) && !fits);
    too_large  = 32'(request_size) > (32'(1) << MAX_SIZE_EXP);
    exp_v  = ceil_pow2_exp(request_size);
    if (too_large || 32'(request_size) <= (32'(1) << MIN_SIZE_EXP)) begin
      aclass = '0;
    end else begin
      aclass = CLASS_W'(exp_v - 5'(MIN_SIZE_EXP));
    end
    acnt     = cnt[aclass];
    alloc_ok = need_alloc && !too_large && (acnt != '0);
    pcnt     = cnt[res_class];
  end

  assign sts.alloc_ok     = alloc_ok;
  assign sts.is_free      = (mode == MODE_FREE);
  assign sts.resize_alloc = (mode == MODE_RESIZE);
  assign sts.out_busy     = out_valid && !out_ready;

  // stack top read during decide, push write during push
  always_comb begin
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    ram_addr = {aclass, UNIT_W'(acnt - CNT_W'(1))};
    if (cmd.decide) begin
      ram_en = alloc_ok;
    end else if (cmd.push) begin
      ram_en   = hvalid && !hfull;
      ram_we   = 1'b1;
      ram_addr = {hidx, UNIT_W'(hcnt)};
    end
  end

  scua_ram #(
    .WIDTH (UNIT_W),
    .DEPTH (RAM_DEPTH)
  ) u_stack (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (UNIT_W'(handle_unit)),
    .rdata (ram_rdata)
  );

  // entries below the low-water mark were never overwritten
  assign pop_unit = use_init ? UNIT_W'(pcnt - CNT_W'(1)) : ram_rdata;

  always_ff @(posedge clk) begin
    if (cmd.take && in_valid) begin
      mode         <= in_data[MODE_W-1:0];
      request_size <= in_data[MODE_W +: SIZE_W];
      handle_class <= in_data[MODE_W+SIZE_W +: CLASS_W];
      handle_unit  <= in_data[MODE_W+SIZE_W+CLASS_W +: HUNIT_W];
    end
    if (cmd.decide) begin
      use_init   <= acnt == low[aclass];
      res_status <= ST_OK;
      res_class  <= '0;
      res_unit   <= '0;
      res_bytes  <= '0;
      if (need_alloc) begin
        if (too_large) begin
          res_status <= ST_TOO_LARGE;
        end else if (acnt == '0) begin
          res_status <= ST_NO_UNIT;
        end else begin
          res_class <= aclass;
          res_bytes <= class_bytes(aclass);
        end
      end else if (mode == MODE_RESIZE) begin
        res_class <= handle_class;
        res_unit  <= handle_unit;
        res_bytes <= class_bytes(handle_class);
      end
    end
    if (cmd.pop) begin
      res_unit <= HUNIT_W'(pop_unit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        cnt[c] <= CNT_W'(UNITS_PER_CLASS);
        low[c] <= CNT_W'(UNITS_PER_CLASS);
      end
      total <= '0;
    end else begin
      if (cmd.pop) begin
        cnt[res_class] <= pcnt - CNT_W'(1);
        if (use_init) low[res_class] <= pcnt - CNT_W'(1);
        total <= total + TOTAL_W'(1);
      end else if (cmd.push && hvalid && !hfull) begin
        cnt[hidx] <= hcnt + CNT_W'(1);
        if (total != '0) total <= total - TOTAL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_reg <= {total, res_bytes, res_unit, res_class, res_status};
    end
  end

  assign out_data = OUT_TDATA_W'(out_reg);

endmodule

FILE: sv/size_class_unit_allocator.sv
// channel  | direction | handshake          | payload
// s_*      | in        | s_tvalid/s_tready  | s_tdata: request
// m_*      | out       | m_tvalid/m_tready  | m_tdata: result
//
// One item is in work at a time: decide, pop for an allocate or a moving resize, push for a
// free or a moving resize, then the result load, which waits while the output stalls; a failed
// request, a fitting resize or an unknown mode skips pop and push. The single-port free-stack RAM
// sets this order (read, then write). s_tready returns the cycle after the load.
// A new item is accepted while the previous result waits in the output register.
// Reset needs no clearing pass: per-class counts and low-water marks restore the stacks.
module size_class_unit_allocator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // mode[1:0], request_size[14:2], handle_class[18:15], handle_unit[26:19]
  input  logic [scua_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // status[1:0], out_class[5:2], out_unit[13:6], unit_bytes[26:14],
  // units_in_use[38:27]
  output logic [scua_pkg::OUT_TDATA_W-1:0]  m_tdata
);

  import scua_pkg::*;

  cmd_t cmd;
  sts_t sts;

  scua_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (s_tready)
  );

  scua_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_valid  (s_tvalid),
    .in_data   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
